// ----- rtl/bitmap_run_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap_run_allocator: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define BRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap_run_allocator: next-cycle check failed");

`endif

// ----- rtl/bra_pkg.sv -----
// Types and constants shared by the bitmap run allocator modules.
package bra_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_AW    = 3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_ARG = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] position;
        logic [8:0] length;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] alloc_start;
        logic [7:0] largest_start;
        logic [8:0] largest_length;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic clear;
        logic fit_init;
        logic mod_init;
        logic sweep;
        logic finish;
        logic set_bad;
        logic set_nofit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic is_free;
        logic last_issue;
        logic fit_ok;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/bra_datapath.sv -----
// Datapath: occupancy memory, byte-serial run scanner, fill logic and result register.
`include "bitmap_run_allocator_defines.svh"

module bra_datapath #(
    parameter int MASK_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bra_pkg::t_dp_cmd     i_cmd,
    output bra_pkg::t_dp_status  o_status,
    input  bra_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bra_pkg::t_out_item   o_out_data
);

    localparam int UNITS = MASK_BYTES * bra_pkg::BYTE_BITS;
    localparam int AW    = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam int BW    = bra_pkg::BIT_AW;
    localparam int UW    = AW + BW;
    localparam int LW    = $clog2(UNITS + 1);
    localparam int W     = (LW > 10) ? LW : 10;

    logic [7:0]    r_mem [MASK_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_raddr;
    logic [AW-1:0] r_didx;
    logic          r_dvalid;

    logic          r_mode;
    logic [7:0]    r_pos;
    logic [8:0]    r_len;
    logic [1:0]    r_status_code;
    logic [W-1:0]  r_start;
    logic          r_pass_mod;
    logic          r_fill_val;

    logic [UW-1:0] r_run_s, n_run_s;
    logic [LW-1:0] r_run_l, n_run_l;
    logic [UW-1:0] r_fit_s, n_fit_s;
    logic [LW-1:0] r_fit_l, n_fit_l;
    logic          r_have, n_have;
    logic          r_exact, n_exact;
    logic [UW-1:0] r_best_s, n_best_s;
    logic [LW-1:0] r_best_l, n_best_l;

    logic          r_ovalid;
    bra_pkg::t_out_item r_out;

    logic [W-1:0]  len_ext;
    logic [W-1:0]  pos_ext;
    logic [W-1:0]  mod_start;
    logic [W-1:0]  best_s_ext;
    logic [W-1:0]  best_l_ext;
    logic [7:0]    mod_byte;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          last_issue;
    logic          scan_en;

    assign len_ext    = W'(r_len);
    assign pos_ext    = W'(r_pos);
    assign mod_start  = (r_mode == bra_pkg::MODE_FREE) ? pos_ext : W'(r_fit_s);
    assign best_s_ext = W'(r_best_s);
    assign best_l_ext = W'(r_best_l);
    assign last_issue = (r_raddr == AW'(MASK_BYTES - 1));
    assign scan_en    = r_dvalid || i_cmd.finish;

    // Mark or clear the units of the run that fall in the returned byte.
    always_comb begin
        logic [W-1:0] k_w;
        for (int i = 0; i < 8; i++) begin
            k_w = W'({r_didx, BW'(i)});
            if ((k_w >= r_start) && (k_w < (r_start + len_ext))) begin
                mod_byte[i] = r_fill_val;
            end else begin
                mod_byte[i] = r_rdata[i];
            end
        end
    end

    assign mem_we    = i_cmd.clear || (r_dvalid && r_pass_mod);
    assign mem_waddr = i_cmd.clear ? r_raddr : r_didx;
    assign mem_wdata = i_cmd.clear ? 8'h00 : mod_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_raddr];
    end

    // Advance the run trackers over one byte; the end of the map is fed as an all-used byte.
    always_comb begin
        logic [UW-1:0] rs, fs, bs, k;
        logic [LW-1:0] rl, fl, bl;
        logic          hv, ex;
        logic [7:0]    pb;
        logic [W-1:0]  want;
        rs   = r_run_s;
        rl   = r_run_l;
        fs   = r_fit_s;
        fl   = r_fit_l;
        hv   = r_have;
        ex   = r_exact;
        bs   = r_best_s;
        bl   = r_best_l;
        want = len_ext;
        pb   = i_cmd.finish ? 8'hFF : (r_pass_mod ? mod_byte : r_rdata);
        for (int i = 0; i < 8; i++) begin
            k = {r_didx, BW'(i)};
            if (!pb[i]) begin
                if (rl == '0) begin
                    rs = k;
                end
                rl = rl + 1'b1;
            end else begin
                if (r_pass_mod) begin
                    if (rl > bl) begin
                        bs = rs;
                        bl = rl;
                    end
                end else if (!ex) begin
                    if (W'(rl) == want) begin
                        ex = 1'b1;
                        hv = 1'b1;
                        fs = rs;
                        fl = rl;
                    end else if ((W'(rl) > want) && (!hv || (rl < fl))) begin
                        hv = 1'b1;
                        fs = rs;
                        fl = rl;
                    end
                end
                rl = '0;
            end
        end
        n_run_s  = rs;
        n_run_l  = rl;
        n_fit_s  = fs;
        n_fit_l  = fl;
        n_have   = hv;
        n_exact  = ex;
        n_best_s = bs;
        n_best_l = bl;
    end

    // Control state and the cached longest run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raddr    <= '0;
            r_dvalid   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pass_mod <= 1'b0;
            r_best_s   <= '0;
            r_best_l   <= LW'(UNITS);
        end else begin
            r_dvalid <= i_cmd.sweep;
            if (i_cmd.fit_init || i_cmd.mod_init) begin
                r_raddr <= '0;
            end else if (i_cmd.sweep || i_cmd.clear) begin
                r_raddr <= last_issue ? '0 : r_raddr + 1'b1;
            end
            if (i_cmd.fit_init) begin
                r_pass_mod <= 1'b0;
            end else if (i_cmd.mod_init) begin
                r_pass_mod <= 1'b1;
                r_best_s   <= '0;
                r_best_l   <= '0;
            end else if (scan_en) begin
                r_best_s <= n_best_s;
                r_best_l <= n_best_l;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Transaction fields, scan payload and result register.
    always_ff @(posedge i_clk) begin
        r_didx <= r_raddr;
        if (i_cmd.load) begin
            r_mode        <= i_in_data.mode;
            r_pos         <= i_in_data.position;
            r_len         <= i_in_data.length;
            r_status_code <= bra_pkg::ST_OK;
            r_start       <= '0;
        end
        if (i_cmd.set_bad) begin
            r_status_code <= bra_pkg::ST_BAD_ARG;
        end
        if (i_cmd.set_nofit) begin
            r_status_code <= bra_pkg::ST_NO_FIT;
        end
        if (i_cmd.fit_init) begin
            r_run_s <= '0;
            r_run_l <= '0;
            r_have  <= 1'b0;
            r_exact <= 1'b0;
        end else if (i_cmd.mod_init) begin
            r_run_s    <= '0;
            r_run_l    <= '0;
            r_fill_val <= (r_mode == bra_pkg::MODE_ALLOC);
            r_start    <= mod_start;
        end else if (scan_en) begin
            r_run_s <= n_run_s;
            r_run_l <= n_run_l;
            r_fit_s <= n_fit_s;
            r_fit_l <= n_fit_l;
            r_have  <= n_have;
            r_exact <= n_exact;
        end
        if (i_cmd.emit) begin
            r_out.status         <= r_status_code;
            r_out.alloc_start    <= r_start[7:0];
            r_out.largest_start  <= best_s_ext[7:0];
            r_out.largest_length <= best_l_ext[8:0];
        end
    end

    assign o_status.bad = (r_len == 9'd0)
        || ((r_mode == bra_pkg::MODE_ALLOC) ? (len_ext > W'(UNITS))
                                            : ((pos_ext + len_ext) > W'(UNITS)));
    assign o_status.is_free    = (r_mode == bra_pkg::MODE_FREE);
    assign o_status.last_issue = last_issue;
    assign o_status.fit_ok     = r_have;
    assign o_status.out_free   = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `BRA_ASSERT_NOW(a_alloc_in_map, i_clk, i_rst_n,
        i_cmd.emit && (r_status_code == bra_pkg::ST_OK) && (r_mode == bra_pkg::MODE_ALLOC),
        (r_start + len_ext) <= W'(UNITS))
    `BRA_ASSERT_NOW(a_best_bound, i_clk, i_rst_n, 1'b1, r_best_l <= LW'(UNITS))

endmodule

// ----- rtl/bra_ctrl.sv -----
// Controller: sequences clear, fit scan, fill scan and result hand-off.
`include "bitmap_run_allocator_defines.svh"

module bra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bra_pkg::t_dp_status i_status,
    output bra_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_CLEAR      = 11'b00000000001,
        S_IDLE       = 11'b00000000010,
        S_CHECK      = 11'b00000000100,
        S_FIT        = 11'b00000001000,
        S_FIT_DRAIN  = 11'b00000010000,
        S_FIT_END    = 11'b00000100000,
        S_FIT_DECIDE = 11'b00001000000,
        S_MOD        = 11'b00010000000,
        S_MOD_DRAIN  = 11'b00100000000,
        S_MOD_END    = 11'b01000000000,
        S_RESULT     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.bad) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = S_RESULT;
                end else if (i_status.is_free) begin
                    o_cmd.mod_init = 1'b1;
                    n_state        = S_MOD;
                end else begin
                    o_cmd.fit_init = 1'b1;
                    n_state        = S_FIT;
                end
            end
            S_FIT: begin
                o_cmd.sweep = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_FIT_DRAIN;
                end
            end
            S_FIT_DRAIN: begin
                n_state = S_FIT_END;
            end
            S_FIT_END: begin
                o_cmd.finish = 1'b1;
                n_state      = S_FIT_DECIDE;
            end
            S_FIT_DECIDE: begin
                if (i_status.fit_ok) begin
                    o_cmd.mod_init = 1'b1;
                    n_state        = S_MOD;
                end else begin
                    o_cmd.set_nofit = 1'b1;
                    n_state         = S_RESULT;
                end
            end
            S_MOD: begin
                o_cmd.sweep = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_MOD_DRAIN;
                end
            end
            S_MOD_DRAIN: begin
                n_state = S_MOD_END;
            end
            S_MOD_END: begin
                o_cmd.finish = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `BRA_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_status.out_free)
    `BRA_ASSERT_NEXT(a_load_check, i_clk, i_rst_n, o_cmd.load, r_state == S_CHECK)

endmodule

// ----- rtl/bitmap_run_allocator.sv -----
// Top level of the bitmap run allocator: controller plus datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (mode, position, length)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (status, alloc_start,
//           |           |                        |   largest_start, largest_length)
//
// One transaction is worked on at a time; the occupancy memory is read one byte per
// cycle in each sweep over the map.
// Allocate that fits: a fit sweep, then a fill-and-measure sweep.
// Allocate with no fit: the fit sweep only. Free: the fill-and-measure sweep only.
// Bad argument: answered from the cached longest run.
// After reset a clearing pass zeroes the map; input stalls meanwhile.
// The result sits in an output register, so the next transaction is taken while it waits.
module bitmap_run_allocator #(
    parameter int MASK_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bra_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bra_pkg::t_out_item o_out_data
);

    // Commands from the controller, status back from the datapath.
    bra_pkg::t_dp_cmd    cmd;
    bra_pkg::t_dp_status status;

    // Sequence the clearing pass, the best-fit sweep and the fill sweep.
    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold the map, scan runs byte by byte, mark or clear runs, register the result.
    bra_datapath #(
        .MASK_BYTES (MASK_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- verif/tb_bitmap_run_allocator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_run_allocator: directed table, then random requests.
module tb_bitmap_run_allocator;

    localparam int MAP_BYTES    = 32;
    localparam int UNITS        = MAP_BYTES * bra_pkg::BYTE_BITS;
    localparam int RANDOM_ITEMS = 925;
    // Longest legal transaction is a fitting allocate: two sweeps plus setup.
    localparam int DRAIN_CYCLES = 3 * MAP_BYTES + 16;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 6000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    bra_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    bra_pkg::t_out_item o_out_data;

    bitmap_run_allocator #(
        .MASK_BYTES(MAP_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // One row of the directed table; typed rows carry their result, the rest use the predictor.
    typedef struct {
        bra_pkg::t_in_item  req;
        bit                 typed;
        bra_pkg::t_out_item want;
    } t_dir_row;

    // Shadow of the occupancy map, 1 = unit in use.
    bit                 unit_used [UNITS];
    bra_pkg::t_out_item expected_results [$];
    t_dir_row           dir_rows [$];
    // Runs handed out and not yet returned, so random frees can release real allocations.
    int unsigned live_at [$];
    int unsigned live_len [$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit in_steady    = 1'b0;
    bit out_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // First longest free run; 0/0 when every unit is used.
    function automatic void find_longest_free(output int unsigned run_at,
                                              output int unsigned run_len);
        int unsigned cur_at  = 0;
        int unsigned cur_len = 0;
        run_at  = 0;
        run_len = 0;
        for (int k = 0; k < UNITS; k++) begin
            if (!unit_used[k]) begin
                if (cur_len == 0) cur_at = k;
                cur_len++;
            end else begin
                if (cur_len > run_len) begin
                    run_at  = cur_at;
                    run_len = cur_len;
                end
                cur_len = 0;
            end
        end
        if (cur_len > run_len) begin
            run_at  = cur_at;
            run_len = cur_len;
        end
    endfunction

    // Best fit: first exact run wins, else the smallest longer run, earliest on ties.
    function automatic bit find_best_fit(input int unsigned want, output int unsigned fit_at);
        int unsigned cur_at  = 0;
        int unsigned cur_len = 0;
        int unsigned fit_len = 0;
        bit          found   = 1'b0;
        bit          busy;
        fit_at = 0;
        for (int k = 0; k <= UNITS; k++) begin
            // Treat the end of the map as a used unit so the last run is closed.
            busy = 1'b1;
            if (k < UNITS) busy = unit_used[k];
            if (!busy) begin
                if (cur_len == 0) cur_at = k;
                cur_len++;
            end else begin
                if (cur_len == want) begin
                    fit_at = cur_at;
                    return 1'b1;
                end
                if (cur_len > want && (!found || cur_len < fit_len)) begin
                    found   = 1'b1;
                    fit_at  = cur_at;
                    fit_len = cur_len;
                end
                cur_len = 0;
            end
        end
        return found;
    endfunction

    // Apply one request to the shadow map and return the result the block must give.
    function automatic bra_pkg::t_out_item apply_request(input bra_pkg::t_in_item req);
        bra_pkg::t_out_item res;
        int unsigned        at;
        int unsigned        run_at;
        int unsigned        run_len;
        res = '0;
        if (req.mode == bra_pkg::MODE_ALLOC) begin
            if (req.length == 0 || int'(req.length) > UNITS) begin
                res.status = bra_pkg::ST_BAD_ARG;
            end else if (find_best_fit(req.length, at)) begin
                for (int k = 0; k < req.length; k++) unit_used[at + k] = 1'b1;
                res.status      = bra_pkg::ST_OK;
                res.alloc_start = at[7:0];
            end else begin
                res.status = bra_pkg::ST_NO_FIT;
            end
        end else begin
            if (req.length == 0 || int'(req.position) + int'(req.length) > UNITS) begin
                res.status = bra_pkg::ST_BAD_ARG;
            end else begin
                for (int k = 0; k < req.length; k++) unit_used[req.position + k] = 1'b0;
                res.status      = bra_pkg::ST_OK;
                res.alloc_start = req.position;
            end
        end
        find_longest_free(run_at, run_len);
        res.largest_start  = run_at[7:0];
        res.largest_length = run_len[8:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input bra_pkg::t_out_item got);
        bra_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding (status)", got.status, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.alloc_start != want.alloc_start)
            report_mismatch("alloc_start", got.alloc_start, want.alloc_start);
        if (got.largest_start != want.largest_start)
            report_mismatch("largest_start", got.largest_start, want.largest_start);
        if (got.largest_length != want.largest_length)
            report_mismatch("largest_length", got.largest_length, want.largest_length);
    endtask

    // Sample the output channel at the edge, before the block updates its registers.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            check_result(o_out_data);
        end
    end

    // Watchdog: end the run if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL bitmap_run_allocator");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void add_row(input logic mode, input int pos, input int len,
                                    input bit typed, input logic [1:0] st, input int a_start,
                                    input int l_start, input int l_len);
        t_dir_row row;
        row.req.mode           = mode;
        row.req.position       = 8'(pos);
        row.req.length         = 9'(len);
        row.typed              = typed;
        row.want.status        = st;
        row.want.alloc_start   = 8'(a_start);
        row.want.largest_start = 8'(l_start);
        row.want.largest_length = 9'(l_len);
        dir_rows.push_back(row);
    endfunction

    // Offer one transaction after a random gap and hold it until the block takes it.
    // Valid stays high on return so a back-to-back transaction needs no second write.
    task automatic send_item(input bra_pkg::t_in_item req, input bit typed,
                             input bra_pkg::t_out_item typed_want);
        int                 gap;
        bra_pkg::t_out_item want;
        gap = in_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        want = apply_request(req);
        if (want.status == bra_pkg::ST_OK) begin
            if (req.mode == bra_pkg::MODE_ALLOC) begin
                live_at.push_back(want.alloc_start);
                live_len.push_back(req.length);
            end else if (req.position == 0 && int'(req.length) == UNITS) begin
                live_at.delete();
                live_len.delete();
            end
        end
        expected_results.push_back(typed ? typed_want : want);
    endtask

    // Random request: mostly well-formed alloc / free pairs, with bad and arbitrary ones mixed in.
    function automatic bra_pkg::t_in_item draw_request();
        bra_pkg::t_in_item req;
        int                pick;
        int unsigned       idx;
        int unsigned       pos;
        pick = $urandom_range(0, 99);
        req.position = 8'($urandom_range(0, 255));
        if (pick < 40 && live_at.size() > 0) begin
            // Return a run that the block handed out earlier.
            idx          = $urandom_range(0, live_at.size() - 1);
            req.mode     = bra_pkg::MODE_FREE;
            req.position = 8'(live_at[idx]);
            req.length   = 9'(live_len[idx]);
            live_at.delete(idx);
            live_len.delete(idx);
        end else if (pick < 75) begin
            req.mode = bra_pkg::MODE_ALLOC;
            if ($urandom_range(0, 99) < 85)
                req.length = 9'($urandom_range(1, 24));
            else
                req.length = 9'($urandom_range(25, UNITS));
        end else if (pick < 82) begin
            // Zero length or longer than the map.
            req.mode = bra_pkg::MODE_ALLOC;
            if ($urandom_range(0, 1) == 0)
                req.length = '0;
            else
                req.length = 9'($urandom_range(UNITS + 1, 511));
        end else if (pick < 94) begin
            // Arbitrary free: may hit free units, cut live runs, or run past the end.
            req.mode = bra_pkg::MODE_FREE;
            pos      = req.position;
            if ($urandom_range(0, 1) == 0)
                req.length = 9'($urandom_range(1, UNITS - pos));
            else
                req.length = 9'($urandom_range(0, 511));
        end else if (pick < 96) begin
            req.mode     = bra_pkg::MODE_FREE;
            req.position = '0;
            req.length   = 9'(UNITS);
        end else begin
            req.mode   = bra_pkg::MODE_ALLOC;
            req.length = 9'($urandom_range(1, 8));
        end
        return req;
    endfunction

    // Sender: reset, directed table, random part, then drain and report.
    initial begin : in_side
        bra_pkg::t_in_item req;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        for (int k = 0; k < UNITS; k++) unit_used[k] = 1'b0;

        // Rejected arguments on an empty map: zero length, too long, free past the end.
        add_row(bra_pkg::MODE_ALLOC,   0,   0, 1, bra_pkg::ST_BAD_ARG,   0,   0, 256);
        add_row(bra_pkg::MODE_FREE,    0,   0, 1, bra_pkg::ST_BAD_ARG,   0,   0, 256);
        add_row(bra_pkg::MODE_ALLOC,   0, 257, 1, bra_pkg::ST_BAD_ARG,   0,   0, 256);
        add_row(bra_pkg::MODE_ALLOC, 255, 511, 1, bra_pkg::ST_BAD_ARG,   0,   0, 256);
        add_row(bra_pkg::MODE_FREE,  255,   2, 1, bra_pkg::ST_BAD_ARG,   0,   0, 256);
        // Freeing units that are already free is legal.
        add_row(bra_pkg::MODE_FREE,    0, 256, 1, bra_pkg::ST_OK,        0,   0, 256);
        // Fill the whole map, find nothing left, then free and refill the last unit and empty the map.
        add_row(bra_pkg::MODE_ALLOC,   0, 256, 1, bra_pkg::ST_OK,        0,   0,   0);
        add_row(bra_pkg::MODE_ALLOC,   0,   1, 1, bra_pkg::ST_NO_FIT,    0,   0,   0);
        add_row(bra_pkg::MODE_FREE,  255,   1, 1, bra_pkg::ST_OK,      255, 255,   1);
        add_row(bra_pkg::MODE_ALLOC,   0,   2, 1, bra_pkg::ST_NO_FIT,    0, 255,   1);
        add_row(bra_pkg::MODE_ALLOC,   0,   1, 1, bra_pkg::ST_OK,      255,   0,   0);
        add_row(bra_pkg::MODE_FREE,    0, 256, 1, bra_pkg::ST_OK,        0,   0, 256);
        // Build a hole of 10 at 0 and a tail of 241 at 15 for best-fit choices.
        add_row(bra_pkg::MODE_ALLOC,   0,  10, 0, bra_pkg::ST_OK,        0,  10, 246);
        add_row(bra_pkg::MODE_ALLOC,   0,   5, 0, bra_pkg::ST_OK,       10,  15, 241);
        add_row(bra_pkg::MODE_ALLOC,   0,  20, 0, bra_pkg::ST_OK,       15,  35, 221);
        add_row(bra_pkg::MODE_FREE,    0,  10, 0, bra_pkg::ST_OK,        0,  35, 221);
        add_row(bra_pkg::MODE_FREE,   15,  20, 0, bra_pkg::ST_OK,       15,  15, 241);
        // Smallest longer run, then an exact run ahead of a longer later one.
        add_row(bra_pkg::MODE_ALLOC,   0,   4, 0, bra_pkg::ST_OK,        0,   0,   0);
        add_row(bra_pkg::MODE_ALLOC,   0,   6, 0, bra_pkg::ST_OK,        0,   0,   0);
        add_row(bra_pkg::MODE_FREE,  128, 128, 0, bra_pkg::ST_OK,      128,  15, 241);
        add_row(bra_pkg::MODE_ALLOC,   0, 241, 0, bra_pkg::ST_OK,       15,   0,   0);
        add_row(bra_pkg::MODE_FREE,  200,  56, 0, bra_pkg::ST_OK,      200, 200,  56);
        add_row(bra_pkg::MODE_FREE,  100,  50, 0, bra_pkg::ST_OK,      100, 200,  56);
        add_row(bra_pkg::MODE_ALLOC,   0,  50, 0, bra_pkg::ST_OK,      100, 200,  56);
        add_row(bra_pkg::MODE_FREE,    0, 100, 0, bra_pkg::ST_OK,        0,   0, 100);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_item(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch between gapped and back-to-back stretches.
            if (n % 64 == 0) in_steady = ($urandom_range(0, 2) == 0);
            // Stop offering until every outstanding result is back.
            if (n == 150 || n == 650) begin
                i_in_valid <= 1'b0;
                while (results_seen != items_sent) @(posedge i_clk);
            end
            // Ask the receiver for a long stall while requests keep coming.
            if (n == 300) out_hold_req = 1'b1;
            req = draw_request();
            send_item(req, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (results_seen != items_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", 0, expected_results.size());
        if (errors == 0)
            $display("PASS bitmap_run_allocator");
        else
            $display("FAIL bitmap_run_allocator");
        $finish;
    end

    // Receiver: may stall before each result, with a long hold when asked.
    initial begin : out_side
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (out_hold_req) begin
                out_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (taken % 64 == 0) steady = ($urandom_range(0, 2) == 0);
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

endmodule
